// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the euler to quaternion RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define E2Q_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("implication check failed");
`define E2Q_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define E2Q_ASSERT_IMPLY(lbl, ante, cons)
`define E2Q_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== hw/rtl/e2q_pkg.sv =====
// Types, constants and elaboration-time tables for the euler to quaternion unit.
package e2q_pkg;
	localparam int FRAC = 30;
	localparam int STAGES = 24;
	localparam int LATENCY = STAGES + 5;

	typedef logic signed [31:0] q30_t;
	typedef logic signed [33:0] xy_t;
	typedef logic signed [34:0] zang_t;

	localparam logic [63:0] PI4_Q62 = 64'h3243F6A8885A308D;
	localparam logic [63:0] GAIN_Q62 = 64'd2800459870029452960;
	localparam logic [63:0] HALF_Q62 = 64'd2147483648;
	localparam logic [32:0] HALF_PI = 33'((PI4_Q62 + PI4_Q62 + HALF_Q62) >> 32);
	localparam xy_t GAIN = xy_t'((GAIN_Q62 + HALF_Q62) >> 32);
	localparam logic signed [33:0] ONE = 34'sd1073741824;

	function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int k = 63; k >= 0; k--) begin
			r = {r[63:0], a[k]};
			if (r >= {1'b0, b}) begin
				r = r - {1'b0, b};
				q[k] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic zang_t atan_tab(input int i);
		logic [63:0] a;
		logic [63:0] t;
		logic [63:0] s3;
		logic [63:0] term;
		logic sub;
		int n;
		a = '0;
		if (i == 0) begin
			a = PI4_Q62;
		end else if (i == 1) begin
			t = (64'd1 << 62) / 64'd3;
			s3 = t;
			sub = 1'b1;
			n = 1;
			for (int k = 0; k < 40; k++) begin
				if (t != 0) begin
					t = t / 64'd9;
					n = n + 2;
					if (sub)
						s3 = s3 - udiv(t, 64'(n));
					else
						s3 = s3 + udiv(t, 64'(n));
					sub = !sub;
				end
			end
			a = PI4_Q62 - s3;
		end else begin
			sub = 1'b0;
			for (n = 1; n * i <= 62; n += 2) begin
				term = udiv(64'd1 << (62 - n * i), 64'(n));
				if (sub)
					a = a - term;
				else
					a = a + term;
				sub = !sub;
			end
		end
		return zang_t'((a + HALF_Q62) >> 32);
	endfunction
endpackage

// ===== hw/rtl/e2q_cordic.sv =====
// Pipelined rotation CORDIC giving sine and cosine of the negated half angle.
module e2q_cordic import e2q_pkg::*; (
	input  logic        clk,
	input  logic [31:0] angle,
	output q30_t        sin_q,
	output q30_t        cos_q
);
	logic [31:0] mag;
	logic [32:0] m;
	logic        fold_c;
	zang_t       z_c;

	xy_t   x_s [STAGES+1];
	xy_t   y_s [STAGES+1];
	zang_t z_s [STAGES+1];
	logic  neg_s [STAGES+1];
	logic  fold_s [STAGES+1];

	logic signed [33:0] cq;
	logic signed [33:0] sq;

	always_comb begin
		mag = angle[31] ? (~angle + 32'd1) : angle;
		m = {mag, 1'b0};
		fold_c = m > HALF_PI;
		z_c = fold_c ? (zang_t'({HALF_PI, 1'b0}) - zang_t'(m)) : zang_t'(m);
	end

	always_ff @(posedge clk) begin
		x_s[0] <= GAIN;
		y_s[0] <= '0;
		z_s[0] <= z_c;
		neg_s[0] <= !angle[31] && (angle != 32'd0);
		fold_s[0] <= fold_c;
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam zang_t ATAN = atan_tab(i);
		always_ff @(posedge clk) begin
			if (!z_s[i][34]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ATAN;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ATAN;
			end
			neg_s[i+1] <= neg_s[i];
			fold_s[i+1] <= fold_s[i];
		end
	end

	always_comb begin
		cq = x_s[STAGES];
		if (x_s[STAGES] > ONE)
			cq = ONE;
		else if (x_s[STAGES] < -ONE)
			cq = -ONE;
		sq = y_s[STAGES];
		if (y_s[STAGES] > ONE)
			sq = ONE;
		else if (y_s[STAGES] < -ONE)
			sq = -ONE;
	end

	always_ff @(posedge clk) begin
		cos_q <= fold_s[STAGES] ? q30_t'(-cq) : q30_t'(cq);
		sin_q <= neg_s[STAGES] ? q30_t'(-sq) : q30_t'(sq);
	end
endmodule

// ===== hw/rtl/e2q_combine.sv =====
// Three-stage product pipeline forming the quaternion from sines and cosines.
module e2q_combine import e2q_pkg::*; (
	input  logic clk,
	input  q30_t sx,
	input  q30_t cx,
	input  q30_t sy,
	input  q30_t cy,
	input  q30_t sz,
	input  q30_t cz,
	output q30_t qx,
	output q30_t qy,
	output q30_t qz,
	output q30_t qw
);
	localparam logic signed [62:0] RND = 63'sd536870912;

	q30_t zy_s1, zzyy_s1, czsy_s1, szcy_s1, sx_s1, cx_s1;
	logic signed [62:0] ax_s2, bx_s2, ay_s2, by_s2, az_s2, bz_s2, aw_s2, bw_s2;
	logic signed [62:0] px, py, pz, pw;

	function automatic q30_t mul30(input q30_t a, input q30_t b);
		logic signed [62:0] p;
		p = 63'(a * b) + RND;
		return q30_t'(p >>> 30);
	endfunction

	function automatic q30_t sat(input logic signed [62:0] v);
		logic signed [62:0] r;
		r = (v + RND) >>> 30;
		if (r > 63'sd1073741824)
			return 32'sd1073741824;
		if (r < -63'sd1073741824)
			return -32'sd1073741824;
		return q30_t'(r);
	endfunction

	always_ff @(posedge clk) begin
		zy_s1 <= mul30(sz, sy);
		zzyy_s1 <= mul30(cz, cy);
		czsy_s1 <= mul30(cz, sy);
		szcy_s1 <= mul30(sz, cy);
		sx_s1 <= sx;
		cx_s1 <= cx;
	end

	always_ff @(posedge clk) begin
		ax_s2 <= 63'(cx_s1 * zy_s1);
		bx_s2 <= 63'(sx_s1 * zzyy_s1);
		ay_s2 <= 63'(cx_s1 * czsy_s1);
		by_s2 <= 63'(sx_s1 * szcy_s1);
		az_s2 <= 63'(cx_s1 * szcy_s1);
		bz_s2 <= 63'(sx_s1 * czsy_s1);
		aw_s2 <= 63'(cx_s1 * zzyy_s1);
		bw_s2 <= 63'(sx_s1 * zy_s1);
	end

	always_comb begin
		px = ax_s2 + bx_s2;
		py = ay_s2 - by_s2;
		pz = az_s2 + bz_s2;
		pw = aw_s2 - bw_s2;
	end

	always_ff @(posedge clk) begin
		qx <= sat(px);
		qy <= sat(py);
		qz <= sat(pz);
		qw <= sat(pw);
	end
endmodule

// ===== hw/rtl/euler_to_quaternion_unit.sv =====
// Top level of the euler angle to unit quaternion converter.
// Usage:
// A word of three angles (angle_x, angle_y, angle_z; radians, signed, 28
// fraction bits) is taken at each rising edge where start is high and busy
// is low. Busy stays low, so one word can be taken in every cycle.
// Each word yields one quaternion word (quat_x, quat_y, quat_z, quat_w;
// signed, 30 fraction bits, within plus or minus one), shown for exactly one
// cycle with done high, once the word has passed the stages listed next.
// The input stage loads on the edge that takes the word; after it come 24
// CORDIC iteration stages, one saturation stage and three product stages.
// Throughput is one word per cycle, sustained without gaps.
// Reset clears the valid pipeline, so no done strobe follows reset until a
// word is started. The receiver cannot stall; results must be taken on the
// cycle done is high.
`include "assert_macros.svh"
module euler_to_quaternion_unit import e2q_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] angle_x,
	input  logic [31:0] angle_y,
	input  logic [31:0] angle_z,
	output logic        done,
	output logic [31:0] quat_x,
	output logic [31:0] quat_y,
	output logic [31:0] quat_z,
	output logic [31:0] quat_w
);
	q30_t sx, cx, sy, cy, sz, cz;
	q30_t qx, qy, qz, qw;
	logic [LATENCY-1:0] valid_q;

	assign busy = 1'b0;

	e2q_cordic u_cx (.clk(clk), .angle(angle_x), .sin_q(sx), .cos_q(cx));
	e2q_cordic u_cy (.clk(clk), .angle(angle_y), .sin_q(sy), .cos_q(cy));
	e2q_cordic u_cz (.clk(clk), .angle(angle_z), .sin_q(sz), .cos_q(cz));

	e2q_combine u_comb (
		.clk(clk), .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
		.qx(qx), .qy(qy), .qz(qz), .qw(qw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[LATENCY-2:0], start && !busy};
		end
	end

	assign done = valid_q[LATENCY-1];
	assign quat_x = qx;
	assign quat_y = qy;
	assign quat_z = qz;
	assign quat_w = qw;

	`E2Q_ASSERT_NEVER(a_never_busy, busy)
	`E2Q_ASSERT_IMPLY(a_x_range, done, $signed(quat_x) <= ONE && $signed(quat_x) >= -ONE)
	`E2Q_ASSERT_IMPLY(a_w_range, done, $signed(quat_w) <= ONE && $signed(quat_w) >= -ONE)
	`E2Q_ASSERT_IMPLY(a_latency, valid_q[0], ##(LATENCY-1) done)
endmodule

// ===== dv/euler_to_quaternion_checker.sv =====
// Checker that predicts and compares every quaternion word of the euler to quaternion unit.
`timescale 1ns / 100ps
module euler_to_quaternion_checker import e2q_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] angle_x,
	input  logic [31:0] angle_y,
	input  logic [31:0] angle_z,
	input  logic        done,
	input  logic [31:0] quat_x,
	input  logic [31:0] quat_y,
	input  logic [31:0] quat_z,
	input  logic [31:0] quat_w,
	output int          fail_count,
	output int          pending
);
	typedef struct packed {
		logic [31:0] qx;
		logic [31:0] qy;
		logic [31:0] qz;
		logic [31:0] qw;
	} quat_word_t;

	localparam int NSTG = 24;
	localparam longint ONE_Q30 = 64'sd1 << 30;
	localparam logic [63:0] PI4 = 64'h3243F6A8885A308D;
	localparam logic [63:0] KGAIN = 64'd2800459870029452960;

	quat_word_t quat_queue[$];
	longint arctan[NSTG];

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rshift(longint v, int s);
		if (s == 0)
			return v;
		return (v + (64'sd1 << (s - 1))) >>> s;
	endfunction

	function automatic longint q62_round(logic [63:0] v);
		return longint'((v + (64'd1 << 31)) >> 32);
	endfunction

	function automatic longint clamp_one(longint v);
		if (v > ONE_Q30)
			return ONE_Q30;
		if (v < -ONE_Q30)
			return -ONE_Q30;
		return v;
	endfunction

	initial begin
		logic [63:0] a, t, s3;
		bit sub;
		int n;
		for (int i = 0; i < NSTG; i++) begin
			if (i == 0) begin
				a = PI4;
			end else if (i == 1) begin
				t = (64'd1 << 62) / 64'd3;
				s3 = t;
				sub = 1;
				n = 1;
				while (t != 0) begin
					t = t / 64'd9;
					n += 2;
					if (sub)
						s3 = s3 - t / 64'(n);
					else
						s3 = s3 + t / 64'(n);
					sub = !sub;
				end
				a = PI4 - s3;
			end else begin
				a = 0;
				sub = 0;
				for (n = 1; n * i <= 62; n += 2) begin
					t = (64'd1 << (62 - n * i)) / 64'(n);
					if (sub)
						a = a - t;
					else
						a = a + t;
					sub = !sub;
				end
			end
			arctan[i] = q62_round(a);
		end
	end

	task automatic half_sin_cos(input logic [31:0] raw, output longint s30,
			output longint c30);
		longint h, m, half_pi, x, y, z, dx, dy;
		bit neg, fold;
		h = -longint'($signed(raw));
		neg = h < 0;
		m = neg ? -h : h;
		m = m <<< 1;
		half_pi = q62_round(PI4 + PI4);
		fold = m > half_pi;
		z = fold ? 2 * half_pi - m : m;
		x = q62_round(KGAIN);
		y = 0;
		for (int i = 0; i < NSTG; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan[i];
			end else begin
				x += dx; y -= dy; z += arctan[i];
			end
		end
		c30 = clamp_one(x);
		s30 = clamp_one(y);
		if (fold)
			c30 = -c30;
		if (neg)
			s30 = -s30;
	endtask

	function automatic longint mul30(longint a, longint b);
		return rshift(a * b, 30);
	endfunction

	function automatic longint sum30(longint p, longint q);
		return clamp_one(rshift(p + q, 30));
	endfunction

	task automatic predict_quat(input logic [31:0] ax, input logic [31:0] ay,
			input logic [31:0] az, output quat_word_t qw);
		longint sx, cx, sy, cy, sz, cz;
		half_sin_cos(ax, sx, cx);
		half_sin_cos(ay, sy, cy);
		half_sin_cos(az, sz, cz);
		qw.qx = 32'(sum30(cx * mul30(sz, sy), sx * mul30(cz, cy)));
		qw.qy = 32'(sum30(cx * mul30(cz, sy), -(sx * mul30(sz, cy))));
		qw.qz = 32'(sum30(cx * mul30(sz, cy), sx * mul30(cz, sy)));
		qw.qw = 32'(sum30(cx * mul30(cz, cy), -(sx * mul30(sz, sy))));
	endtask

	assign pending = quat_queue.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		quat_word_t exp_q;
		if (arst_n && done) begin
			if (quat_queue.size() == 0) begin
				$error("quaternion word with no word waiting");
				fail_count++;
			end else begin
				exp_q = quat_queue.pop_front();
				if (quat_x !== exp_q.qx) begin
					$error("quat_x expected %h actual %h", exp_q.qx, quat_x);
					fail_count++;
				end
				if (quat_y !== exp_q.qy) begin
					$error("quat_y expected %h actual %h", exp_q.qy, quat_y);
					fail_count++;
				end
				if (quat_z !== exp_q.qz) begin
					$error("quat_z expected %h actual %h", exp_q.qz, quat_z);
					fail_count++;
				end
				if (quat_w !== exp_q.qw) begin
					$error("quat_w expected %h actual %h", exp_q.qw, quat_w);
					fail_count++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			predict_quat(angle_x, angle_y, angle_z, exp_q);
			quat_queue.push_back(exp_q);
		end
	end
endmodule

// ===== dv/testbench.sv =====
// Stimulus and verdict for the euler to quaternion unit regression.
`timescale 1ns / 100ps
module testbench;
	import e2q_pkg::*;

	localparam int N_RANDOM = 1530;
	localparam int WATCHDOG = 2000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [31:0] angle_x, angle_y, angle_z;
	logic done;
	logic [31:0] quat_x, quat_y, quat_z, quat_w;
	int fail_count;
	int pending;
	int idle_cycles;

	euler_to_quaternion_unit dut (.*);

	euler_to_quaternion_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [31:0] pick_angle();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'(($urandom_range(0, 1) ? 1 : -1) * 421657428);
			3: return 32'(($urandom_range(0, 1) ? 1 : -1) * 843314857
				+ int'($urandom_range(0, 8)) - 4);
			4: return 32'(int'($urandom_range(0, 64)) - 32);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_word(input logic [31:0] ax, input logic [31:0] ay,
			input logic [31:0] az, input bit allow_gaps);
		int gap;
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		angle_x <= ax;
		angle_y <= ay;
		angle_z <= az;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [31:0] edge_vals[8];
		idle_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		angle_x = '0;
		angle_y = '0;
		angle_z = '0;
		edge_vals = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd421657428,
			-32'sd421657428, 32'd843314857, -32'sd843314857, 32'hFFFF_FFFF};
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int i = 0; i < 8; i++)
			send_word(edge_vals[i], edge_vals[(i + 3) % 8], edge_vals[(i + 5) % 8], 0);
		for (int i = 0; i < 12; i++)
			send_word(edge_vals[$urandom_range(0, 7)], edge_vals[$urandom_range(0, 7)],
				edge_vals[$urandom_range(0, 7)], 1);
		for (int i = 0; i < N_RANDOM; i++)
			send_word(pick_angle(), pick_angle(), pick_angle(), i < N_RANDOM - 200);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== euler_to_quaternion_unit.f =====
+incdir+hw/rtl
hw/rtl/e2q_pkg.sv
hw/rtl/e2q_cordic.sv
hw/rtl/e2q_combine.sv
hw/rtl/euler_to_quaternion_unit.sv
dv/euler_to_quaternion_checker.sv
dv/testbench.sv
